FILE: rtl/sssk_pkg.sv
// sssk_pkg: shared widths, lookup tables and weight functions for the
// seven-segment scan and key editor; no dependencies
package sssk_pkg;

  localparam int VALUE_W = 16;
  localparam int DIGITS  = 4;
  localparam int DIGIT_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 16'd10000;

  // active-low segment pattern per decimal digit, blank above nine
  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] pat;
    unique case (code)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

  // active-low digit select
  function automatic logic [7:0] select_pattern(input logic [DIGIT_W-1:0] digit);
    logic [7:0] pat;
    unique case (digit)
      2'd0:    pat = 8'hF7;
      2'd1:    pat = 8'hFB;
      2'd2:    pat = 8'hFD;
      default: pat = 8'hFE;
    endcase
    return pat;
  endfunction

  // step size 1, 10, 100, 1000 from a two-bit code
  function automatic logic [VALUE_W-1:0] step_weight(input logic [1:0] code);
    logic [VALUE_W-1:0] w;
    unique case (code)
      2'd0:    w = 16'd1;
      2'd1:    w = 16'd10;
      2'd2:    w = 16'd100;
      default: w = 16'd1000;
    endcase
    return w;
  endfunction

  // trial weights for decimal split: 8,4,2,1 times 1000, 100, 10
  function automatic logic [VALUE_W-1:0] digit_weight(input logic [3:0] idx);
    logic [VALUE_W-1:0] w;
    unique case (idx)
      4'd0:    w = 16'd8000;
      4'd1:    w = 16'd4000;
      4'd2:    w = 16'd2000;
      4'd3:    w = 16'd1000;
      4'd4:    w = 16'd800;
      4'd5:    w = 16'd400;
      4'd6:    w = 16'd200;
      4'd7:    w = 16'd100;
      4'd8:    w = 16'd80;
      4'd9:    w = 16'd40;
      4'd10:   w = 16'd20;
      4'd11:   w = 16'd10;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/sssk_alu.sv
// sssk_alu: shared 16-bit add/subtract unit with carry out
// depends on sssk_pkg for the value width
module sssk_alu (
  input  logic [sssk_pkg::VALUE_W-1:0] a,
  input  logic [sssk_pkg::VALUE_W-1:0] b,
  input  logic                         sub,
  output logic [sssk_pkg::VALUE_W-1:0] result,
  output logic                         carry
);

  logic [sssk_pkg::VALUE_W-1:0] b_eff;
  logic [sssk_pkg::VALUE_W:0]   sum;

  assign b_eff = sub ? ~b : b;
  // on subtract, carry high means a >= b
  assign sum    = {1'b0, a} + {1'b0, b_eff} + {{sssk_pkg::VALUE_W{1'b0}}, sub};
  assign result = sum[sssk_pkg::VALUE_W-1:0];
  assign carry  = sum[sssk_pkg::VALUE_W];

endmodule

FILE: rtl/seven_segment_scan_with_key_editor.sv
// seven_segment_scan_with_key_editor: display scan, key debounce and number
// editor, one timer tick per input transfer
// depends on sssk_pkg and sssk_alu
// a tick runs the key actions, then on a refresh a clamp plus 12
// compare-subtract steps on the shared adder, then the output register
// input stalls while a tick is in work
// reset: pin registers low, output invalid, value zero, step 1, digits and keys cleared
module seven_segment_scan_with_key_editor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        key_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        serial_data,
  output logic        shift_clock,
  output logic        latch_strobe,
  output logic        data_released,
  output logic [15:0] edited_value,
  output logic [1:0]  digit_in_scan
);

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REPEAT   = 2'd1;
  localparam logic [1:0] REG_REFRESH  = 2'd2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACT   = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_DIG   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] PH_DATA     = 3'd0;
  localparam logic [2:0] PH_CLK_HIGH = 3'd1;
  localparam logic [2:0] PH_CLK_LOW  = 3'd2;
  localparam logic [2:0] PH_LATCH_HI = 3'd3;
  localparam logic [2:0] PH_LATCH_LO = 3'd4;
  localparam logic [2:0] PH_RELEASE  = 3'd5;

  localparam logic [1:0] KEY_DEC  = 2'd1;
  localparam logic [1:0] KEY_INC  = 2'd2;
  localparam logic [1:0] KEY_STEP = 2'd3;

  localparam logic [3:0] DIG_LAST = 4'd11;

  localparam int VW = sssk_pkg::VALUE_W;
  localparam int DW = sssk_pkg::DIGIT_W;

  logic [7:0]    debounce_count;
  logic [7:0]    repeat_after;
  logic [15:0]   refresh_period;

  logic [2:0]    state;
  logic [2:0]    step_phase;
  logic [3:0]    bit_index;
  logic [DW-1:0] scan_index;
  logic          pin_data;
  logic          pin_clock;
  logic          pin_latch;
  logic          pin_released;
  logic [VW-1:0] value;
  logic [1:0]    step_code;
  logic [3:0]    shown_digits [sssk_pkg::DIGITS];
  logic          key_previous [sssk_pkg::DIGITS];
  logic [7:0]    key_hold_count [sssk_pkg::DIGITS];
  logic [15:0]   refresh_ticks;

  logic [1:0]    act_left;
  logic [1:0]    act_key;
  logic          do_refresh;
  logic [DW-1:0] tick_digit;
  logic [VW-1:0] work_value;
  logic [2:0]    digit_acc;
  logic [3:0]    dig_count;

  logic          in_accept;
  logic [15:0]   pattern;
  logic          hold_continue;
  logic [7:0]    hold_next;
  logic          fire_first;
  logic          fire_repeat;
  logic [1:0]    fire_total;
  logic          refresh_now;

  logic [VW-1:0] alu_a;
  logic [VW-1:0] alu_b;
  logic          alu_sub;
  logic [VW-1:0] alu_result;
  logic          alu_carry;
  logic [VW-1:0] work_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && (state == ST_IDLE);

  assign pattern = {sssk_pkg::select_pattern(scan_index),
                    sssk_pkg::seg_pattern(shown_digits[scan_index])};

  // key sample for the digit in scan
  assign hold_continue = (key_previous[scan_index] == key_level) && key_level;
  assign hold_next     = hold_continue ? key_hold_count[scan_index] + 8'd1 : 8'd0;
  assign fire_first    = hold_continue && (hold_next == debounce_count);
  assign fire_repeat   = hold_continue && (hold_next > repeat_after);
  assign fire_total    = {1'b0, fire_first} + {1'b0, fire_repeat};
  assign refresh_now   = (refresh_ticks >= refresh_period);

  always_comb begin
    unique case (state)
      ST_ACT: begin
        alu_a   = value;
        alu_b   = sssk_pkg::step_weight(step_code);
        alu_sub = (act_key == KEY_DEC);
      end
      ST_CLAMP: begin
        alu_a   = value;
        alu_b   = sssk_pkg::VALUE_LIMIT;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = work_value;
        alu_b   = sssk_pkg::digit_weight(dig_count);
        alu_sub = 1'b1;
      end
    endcase
  end

  sssk_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_result),
    .carry  (alu_carry)
  );

  assign work_next = alu_carry ? alu_result : work_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= 8'd3;
      repeat_after   <= 8'd50;
      refresh_period <= 16'd1000;
      state          <= ST_IDLE;
      step_phase     <= PH_DATA;
      bit_index      <= 4'd15;
      scan_index     <= '0;
      pin_data       <= 1'b0;
      pin_clock      <= 1'b0;
      pin_latch      <= 1'b0;
      pin_released   <= 1'b0;
      value          <= '0;
      step_code      <= 2'd0;
      refresh_ticks  <= '0;
      act_left       <= 2'd0;
      do_refresh     <= 1'b0;
      dig_count      <= 4'd0;
      out_valid      <= 1'b0;
      for (int i = 0; i < sssk_pkg::DIGITS; i++) begin
        shown_digits[i]   <= 4'd0;
        key_previous[i]   <= 1'b0;
        key_hold_count[i] <= 8'd0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEBOUNCE: debounce_count <= cfg_data[7:0];
          REG_REPEAT:   repeat_after   <= cfg_data[7:0];
          REG_REFRESH:  refresh_period <= cfg_data;
          default:      ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            tick_digit    <= scan_index;
            act_key       <= scan_index;
            do_refresh    <= refresh_now;
            refresh_ticks <= refresh_now ? 16'd0 : refresh_ticks + 16'd1;
            act_left      <= 2'd0;
            state         <= refresh_now ? ST_CLAMP : ST_OUT;
            unique case (step_phase)
              PH_DATA: begin
                pin_data   <= pattern[bit_index];
                step_phase <= PH_CLK_HIGH;
              end
              PH_CLK_HIGH: begin
                pin_clock  <= 1'b1;
                step_phase <= PH_CLK_LOW;
              end
              PH_CLK_LOW: begin
                pin_clock <= 1'b0;
                if (bit_index == 4'd0) begin
                  bit_index  <= 4'd15;
                  step_phase <= PH_LATCH_HI;
                end else begin
                  bit_index  <= bit_index - 4'd1;
                  step_phase <= PH_DATA;
                end
              end
              PH_LATCH_HI: begin
                pin_latch  <= 1'b1;
                step_phase <= PH_LATCH_LO;
              end
              PH_LATCH_LO: begin
                pin_latch  <= 1'b0;
                step_phase <= PH_RELEASE;
              end
              PH_RELEASE: begin
                pin_released <= 1'b1;
                step_phase   <= 3'd6;
              end
              default: begin
                key_hold_count[scan_index] <= hold_next;
                key_previous[scan_index]   <= key_level;
                pin_released               <= 1'b0;
                scan_index                 <= scan_index + 2'd1;
                step_phase                 <= PH_DATA;
                act_left                   <= fire_total;
                if (fire_total != 2'd0) begin
                  state <= ST_ACT;
                end
              end
            endcase
          end
        end
        ST_ACT: begin
          if (act_key == KEY_DEC || act_key == KEY_INC) begin
            value <= alu_result;
          end else if (act_key == KEY_STEP) begin
            // code wraps from 1000 back to 1
            step_code <= step_code + 2'd1;
          end
          act_left <= act_left - 2'd1;
          if (act_left == 2'd1) begin
            state <= do_refresh ? ST_CLAMP : ST_OUT;
          end
        end
        ST_CLAMP: begin
          if (alu_carry) begin
            value      <= '0;
            work_value <= '0;
          end else begin
            work_value <= value;
          end
          dig_count <= 4'd0;
          state     <= ST_DIG;
        end
        ST_DIG: begin
          work_value <= work_next;
          digit_acc  <= {digit_acc[1:0], alu_carry};
          if (dig_count[1:0] == 2'd3) begin
            // thousands, hundreds, tens land in digits three, two, one
            shown_digits[~dig_count[3:2]] <= {digit_acc, alu_carry};
          end
          if (dig_count == DIG_LAST) begin
            shown_digits[0] <= work_next[3:0];
            state           <= ST_OUT;
          end
          dig_count <= dig_count + 4'd1;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            serial_data   <= pin_data;
            shift_clock   <= pin_clock;
            latch_strobe  <= pin_latch;
            data_released <= pin_released;
            edited_value  <= value;
            digit_in_scan <= tick_digit;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
